// ----- hdl/ffa_pkg.sv -----
`timescale 1ns / 1ps
package ffa_pkg;

    localparam int POOL_BYTES   = 1024;
    localparam int MAX_SEGMENTS = 1024;

    localparam int START_W = $clog2(POOL_BYTES);
    localparam int SIZE_W  = $clog2(POOL_BYTES + 1);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W   = $clog2(MAX_SEGMENTS);
    localparam int REQ_W   = 11;
    localparam int OFS_W   = 10;
    localparam int STAT_W  = 11;
    localparam int CMP_W   = (SIZE_W > REQ_W) ? SIZE_W : REQ_W;

    typedef logic [START_W-1:0] start_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [IDX_W-1:0]   pidx_t;
    typedef logic [CMP_W-1:0]   cmp_t;
    typedef logic [STAT_W-1:0]  stat_t;
    typedef logic [OFS_W-1:0]   ofs_t;

    localparam stat_t STAT_MAX = '1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_BADFREE = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_PASS,
        S_DRAIN,
        S_REPORT
    } state_t;

    // one table entry as it travels along the chain
    typedef struct packed {
        logic   valid;
        logic   used;
        start_t start;
        size_t  size;
    } seg_t;

    localparam seg_t SEG_EMPTY = '{valid: 1'b0, used: 1'b0, start: '0, size: '0};
    localparam seg_t SEG_INIT0 = '{valid: 1'b1, used: 1'b0, start: '0,
                                   size: size_t'(POOL_BYTES)};

    typedef struct packed {
        logic              func;
        logic [REQ_W-1:0]  request_size;
        ofs_t              release_offset;
    } req_t;

    typedef struct packed {
        status_t status;
        ofs_t    block_offset;
        stat_t   free_total;
        stat_t   largest_free;
        stat_t   fragmentation;
    } rsp_t;

    function automatic stat_t sat_stat(input size_t v);
        cmp_t w;
        w = cmp_t'(v);
        if (w > cmp_t'(STAT_MAX))
            return STAT_MAX;
        else
            return stat_t'(w);
    endfunction

    function automatic ofs_t ofs_of(input start_t s);
        logic [START_W+OFS_W-1:0] w;
        w = {{OFS_W{1'b0}}, s};
        return w[OFS_W-1:0];
    endfunction

    function automatic logic start_is(input start_t s, input ofs_t r);
        return {{OFS_W{1'b0}}, s} == {{START_W{1'b0}}, r};
    endfunction

endpackage

// ----- hdl/ffa_cell.sv -----
`timescale 1ns / 1ps
module ffa_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  ffa_pkg::seg_t init,
    input  ffa_pkg::seg_t din,
    output ffa_pkg::seg_t seg
);

    ffa_pkg::seg_t seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= init;
        else if (shift)
            seg_reg <= din;
    end

    assign seg = seg_reg;

endmodule

// ----- hdl/ffa_ctrl.sv -----
`timescale 1ns / 1ps
module ffa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  ffa_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_ready,
    output ffa_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  ffa_pkg::seg_t head,
    output ffa_pkg::seg_t tail,
    output logic          shift
);

    ffa_pkg::state_t  state_reg, state_next;
    ffa_pkg::req_t    item_reg, item_next;
    ffa_pkg::seg_t    a_reg, a_next;
    logic             found_reg, found_next;
    ffa_pkg::status_t status_reg, status_next;
    ffa_pkg::start_t  offset_reg, offset_next;
    ffa_pkg::cnt_t    count_reg, count_next;
    ffa_pkg::size_t   total_reg, total_next;
    ffa_pkg::size_t   largest_reg, largest_next;
    ffa_pkg::pidx_t   pass_reg, pass_next;
    logic             drain_first_reg, drain_first_next;
    ffa_pkg::rsp_t    rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ffa_pkg::S_IDLE;
            a_reg           <= ffa_pkg::SEG_EMPTY;
            count_reg       <= ffa_pkg::cnt_t'(1);
            rsp_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            drain_first_reg <= 1'b0;
            pass_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            a_reg           <= a_next;
            count_reg       <= count_next;
            rsp_valid_reg   <= rsp_valid_next;
            found_reg       <= found_next;
            drain_first_reg <= drain_first_next;
            pass_reg        <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        status_reg  <= status_next;
        offset_reg  <= offset_next;
        total_reg   <= total_next;
        largest_reg <= largest_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        ffa_pkg::seg_t xp;
        ffa_pkg::seg_t e2;
        ffa_pkg::cmp_t sum;
        logic          hit;
        logic          split;
        logic          stat_en;

        state_next       = state_reg;
        item_next        = item_reg;
        a_next           = a_reg;
        found_next       = found_reg;
        status_next      = status_reg;
        offset_next      = offset_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        largest_next     = largest_reg;
        pass_next        = pass_reg;
        drain_first_next = drain_first_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;
        req_ready        = 1'b0;
        shift            = 1'b0;
        tail             = ffa_pkg::SEG_EMPTY;
        xp               = head;
        e2               = ffa_pkg::SEG_EMPTY;
        hit              = 1'b0;
        split            = 1'b0;
        stat_en          = 1'b0;
        sum              = ffa_pkg::cmp_t'(head.start) + ffa_pkg::cmp_t'(item_reg.request_size);

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    item_next    = req;
                    found_next   = 1'b0;
                    status_next  = (req.func == ffa_pkg::FUNC_FREE) ?
                                   ffa_pkg::ST_BADFREE : ffa_pkg::ST_NOFIT;
                    offset_next  = '0;
                    total_next   = '0;
                    largest_next = '0;
                    pass_next    = '0;
                    a_next       = ffa_pkg::SEG_EMPTY;
                    state_next   = ffa_pkg::S_ALIGN;
                end
            end

            ffa_pkg::S_ALIGN:
            begin
                // rotate until the segment at pool offset zero sits at the head
                if (head.valid && head.start == '0)
                    state_next = ffa_pkg::S_PASS;
                else
                begin
                    shift = 1'b1;
                    tail  = head;
                end
            end

            ffa_pkg::S_PASS:
            begin
                shift     = 1'b1;
                stat_en   = 1'b1;
                pass_next = pass_reg + 1'b1;
                if (pass_reg == ffa_pkg::pidx_t'(ffa_pkg::MAX_SEGMENTS - 1))
                begin
                    state_next       = ffa_pkg::S_DRAIN;
                    drain_first_next = 1'b1;
                end

                if (item_reg.func == ffa_pkg::FUNC_ALLOC)
                begin
                    hit = head.valid && !found_reg && (item_reg.request_size != '0) &&
                          !head.used &&
                          (ffa_pkg::cmp_t'(head.size) >= ffa_pkg::cmp_t'(item_reg.request_size));
                    if (hit)
                    begin
                        found_next  = 1'b1;
                        offset_next = head.start;
                        if (ffa_pkg::cmp_t'(head.size) > ffa_pkg::cmp_t'(item_reg.request_size))
                        begin
                            if (count_reg == ffa_pkg::cnt_t'(ffa_pkg::MAX_SEGMENTS))
                                status_next = ffa_pkg::ST_FULL;
                            else
                            begin
                                split       = 1'b1;
                                xp.used     = 1'b1;
                                xp.size     = ffa_pkg::size_t'(item_reg.request_size);
                                e2.valid    = 1'b1;
                                e2.used     = 1'b0;
                                e2.start    = ffa_pkg::start_t'(sum);
                                e2.size     = head.size - ffa_pkg::size_t'(item_reg.request_size);
                                count_next  = count_reg + 1'b1;
                                status_next = ffa_pkg::ST_OK;
                            end
                        end
                        else
                        begin
                            xp.used     = 1'b1;
                            status_next = ffa_pkg::ST_OK;
                        end
                    end

                    if (a_reg.valid)
                    begin
                        tail   = a_reg;
                        a_next = xp;
                    end
                    else
                    begin
                        tail = xp;
                        if (split)
                            a_next = e2;
                    end
                end
                else
                begin
                    hit = head.valid && !found_reg && head.used &&
                          ffa_pkg::start_is(head.start, item_reg.release_offset);
                    if (hit)
                    begin
                        found_next  = 1'b1;
                        xp.used     = 1'b0;
                        offset_next = head.start;
                        status_next = ffa_pkg::ST_OK;
                    end

                    // held entry lags one slot so a free neighbor can fold into it;
                    // holes pass straight by so neighbors across a hole still meet
                    if (!xp.valid)
                        tail = xp;
                    else if (a_reg.valid && !a_reg.used && !xp.used)
                    begin
                        a_next.size = a_reg.size + xp.size;
                        count_next  = count_reg - 1'b1;
                    end
                    else
                    begin
                        tail   = a_reg;
                        a_next = xp;
                    end
                end
            end

            ffa_pkg::S_DRAIN:
            begin
                // push the held entry out until a hole is absorbed
                if (!a_reg.valid)
                    state_next = ffa_pkg::S_REPORT;
                else
                begin
                    shift            = 1'b1;
                    tail             = a_reg;
                    a_next           = head;
                    stat_en          = drain_first_reg;
                    drain_first_next = 1'b0;
                end
            end

            ffa_pkg::S_REPORT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.block_offset  = (status_reg == ffa_pkg::ST_OK) ?
                                             ffa_pkg::ofs_of(offset_reg) : '0;
                    rsp_next.free_total    = ffa_pkg::sat_stat(total_reg);
                    rsp_next.largest_free  = ffa_pkg::sat_stat(largest_reg);
                    rsp_next.fragmentation = ffa_pkg::sat_stat(total_reg - largest_reg);
                    rsp_valid_next         = 1'b1;
                    state_next             = ffa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffa_pkg::S_IDLE;
            end
        endcase

        if (stat_en && tail.valid && !tail.used)
        begin
            total_next = total_reg + tail.size;
            if (tail.size > largest_reg)
                largest_next = tail.size;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- hdl/first_fit_allocator_core.sv -----
`timescale 1ns / 1ps
// First-fit byte-pool allocator with coalescing. The segment table lives in a
// ring of MAX_SEGMENTS cells, one segment (or an empty hole) per cell; the ring
// rotates one cell per clock whenever the single control unit at its head
// shifts it; that unit searches, splits and merges entries as they stream
// past and sums the free sizes on the way. One request at a time: after the
// req transfer the ring first rotates until the segment at pool offset zero
// reaches the head, then makes one full turn, then shifts on until a
// held-back entry absorbs a hole, then the result is registered in rsp. The
// block returns to idle before it takes the next req. The rsp register holds
// a finished result while the next request is already taken and worked on;
// a request that finishes while that result is still unread waits until rsp
// is taken.
module first_fit_allocator_core (
    input  logic          clk,
    input  logic          rst_n,
    input  ffa_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_ready,
    output ffa_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_ready
);

    ffa_pkg::seg_t ring [ffa_pkg::MAX_SEGMENTS];
    ffa_pkg::seg_t tail;
    logic          shift;

    // cell k takes from cell k+1; the last cell is fed by the control unit
    for (genvar k = 0; k < ffa_pkg::MAX_SEGMENTS; k++)
    begin : g_ring
        ffa_pkg::seg_t din;
        ffa_pkg::seg_t init;

        if (k == ffa_pkg::MAX_SEGMENTS - 1)
        begin : g_last
            assign din = tail;
        end
        else
        begin : g_mid
            assign din = ring[k+1];
        end

        // after reset, cell 0 holds one free segment covering the pool
        if (k == 0)
        begin : g_first
            assign init = ffa_pkg::SEG_INIT0;
        end
        else
        begin : g_rest
            assign init = ffa_pkg::SEG_EMPTY;
        end

        ffa_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .init  (init),
            .din   (din),
            .seg   (ring[k])
        );
    end

    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .head      (ring[0]),
        .tail      (tail),
        .shift     (shift)
    );

endmodule

// ----- tb/sv/tb_first_fit_allocator_core.sv -----
`timescale 1ns / 1ps
module tb_first_fit_allocator_core;

    localparam int NUM_RANDOM  = 270;
    localparam int IDLE_LIMIT  = 40000;
    localparam int LONG_HOLD   = 12000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    ffa_pkg::req_t req = '0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    ffa_pkg::rsp_t rsp;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;

    first_fit_allocator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .rsp      (rsp),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready)
    );

    always #4 clk = ~clk;

    // predictor copy of the segment table
    int unsigned tbl_start[ffa_pkg::MAX_SEGMENTS];
    int unsigned tbl_size[ffa_pkg::MAX_SEGMENTS];
    bit          tbl_used[ffa_pkg::MAX_SEGMENTS];
    int unsigned tbl_count;

    ffa_pkg::rsp_t pending_rsp[$];
    int unsigned   live_offsets[$];
    int            errors = 0;
    bit            sender_done = 1'b0;
    bit            hold_active = 1'b0;
    int            idle_cycles = 0;

    function automatic ffa_pkg::stat_t clip_stat(int unsigned v);
        return (v > 2047) ? ffa_pkg::stat_t'(2047) : ffa_pkg::stat_t'(v);
    endfunction

    function automatic void drop_seg(int unsigned k);
        for (int unsigned j = k; j + 1 < tbl_count; j++) begin
            tbl_start[j] = tbl_start[j+1];
            tbl_size[j]  = tbl_size[j+1];
            tbl_used[j]  = tbl_used[j+1];
        end
        tbl_count--;
    endfunction

    function automatic ffa_pkg::rsp_t apply_request(ffa_pkg::req_t r);
        ffa_pkg::rsp_t    o;
        ffa_pkg::status_t st;
        int unsigned ofs = 0;
        int unsigned tot = 0;
        int unsigned big = 0;
        int unsigned i;
        int unsigned sz;
        sz = r.request_size;
        if (r.func == ffa_pkg::FUNC_ALLOC) begin
            st = ffa_pkg::ST_NOFIT;
            if (sz != 0) begin
                for (i = 0; i < tbl_count; i++)
                    if (!tbl_used[i] && tbl_size[i] >= sz) break;
                if (i < tbl_count) begin
                    if (tbl_size[i] > sz) begin
                        if (tbl_count >= ffa_pkg::MAX_SEGMENTS) st = ffa_pkg::ST_FULL;
                        else begin
                            for (int unsigned j = tbl_count; j > i + 1; j--) begin
                                tbl_start[j] = tbl_start[j-1];
                                tbl_size[j]  = tbl_size[j-1];
                                tbl_used[j]  = tbl_used[j-1];
                            end
                            tbl_start[i+1] = tbl_start[i] + sz;
                            tbl_size[i+1]  = tbl_size[i] - sz;
                            tbl_used[i+1]  = 1'b0;
                            tbl_count++;
                            tbl_size[i] = sz;
                            tbl_used[i] = 1'b1;
                            st  = ffa_pkg::ST_OK;
                            ofs = tbl_start[i];
                        end
                    end else begin
                        tbl_used[i] = 1'b1;
                        st  = ffa_pkg::ST_OK;
                        ofs = tbl_start[i];
                    end
                end
            end
        end else begin
            st = ffa_pkg::ST_BADFREE;
            for (i = 0; i < tbl_count; i++)
                if (tbl_used[i] && tbl_start[i] == r.release_offset) break;
            if (i < tbl_count) begin
                tbl_used[i] = 1'b0;
                if (i + 1 < tbl_count && !tbl_used[i+1]) begin
                    tbl_size[i] += tbl_size[i+1];
                    drop_seg(i + 1);
                end
                if (i > 0 && !tbl_used[i-1]) begin
                    tbl_size[i-1] += tbl_size[i];
                    drop_seg(i);
                end
                st  = ffa_pkg::ST_OK;
                ofs = r.release_offset;
            end
        end
        for (i = 0; i < tbl_count; i++)
            if (!tbl_used[i]) begin
                tot += tbl_size[i];
                if (tbl_size[i] > big) big = tbl_size[i];
            end
        o.status        = st;
        o.block_offset  = ffa_pkg::ofs_t'(ofs);
        o.free_total    = clip_stat(tot);
        o.largest_free  = clip_stat(big);
        o.fragmentation = clip_stat(tot - big);
        return o;
    endfunction

    // live block list steers frees toward valid offsets
    function automatic void track_live(ffa_pkg::req_t r, ffa_pkg::rsp_t o);
        if (o.status != ffa_pkg::ST_OK) return;
        if (r.func == ffa_pkg::FUNC_ALLOC) live_offsets.push_back(o.block_offset);
        else
            foreach (live_offsets[k])
                if (live_offsets[k] == o.block_offset) begin
                    live_offsets.delete(k);
                    break;
                end
    endfunction

    // called at a falling edge; leaves valid high, a gap in the next call or the sender drops it
    task automatic send_req(ffa_pkg::req_t r, bit has_fixed, ffa_pkg::rsp_t fixed);
        ffa_pkg::rsp_t pred;
        int            gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        pred = apply_request(r);
        if (has_fixed && pred != fixed)
            $display("%0t: table row disagrees: row %h predictor %h", $time, fixed, pred);
        if (has_fixed) pending_rsp.push_back(fixed);
        else pending_rsp.push_back(pred);
        track_live(r, pred);
        @(negedge clk);
    endtask

    function automatic ffa_pkg::rsp_t mk(ffa_pkg::status_t s, int unsigned o, int unsigned t,
                                         int unsigned b);
        ffa_pkg::rsp_t x;
        x.status = s;
        x.block_offset = ffa_pkg::ofs_t'(o);
        x.free_total = ffa_pkg::stat_t'(t);
        x.largest_free = ffa_pkg::stat_t'(b);
        x.fragmentation = ffa_pkg::stat_t'(t - b);
        return x;
    endfunction

    function automatic ffa_pkg::req_t mkreq(logic f, int unsigned sz, int unsigned ofs);
        ffa_pkg::req_t r;
        r.func = f;
        r.request_size = sz[ffa_pkg::REQ_W-1:0];
        r.release_offset = ffa_pkg::ofs_t'(ofs);
        return r;
    endfunction

    typedef struct {
        ffa_pkg::req_t r;
        bit            fixed;
        ffa_pkg::rsp_t o;
    } stim_row_t;

    // sender
    initial begin
        stim_row_t     rows[$];
        ffa_pkg::req_t r;
        int            pick;
        int unsigned   sz;
        tbl_count    = 1;
        tbl_start[0] = 0;
        tbl_size[0]  = ffa_pkg::POOL_BYTES;
        tbl_used[0]  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero size, oversize, bad free, whole pool grab and release
        rows.push_back('{mkreq(ffa_pkg::FUNC_ALLOC, 0, 0), 1,
                         mk(ffa_pkg::ST_NOFIT, 0, 1024, 1024)});
        rows.push_back('{mkreq(ffa_pkg::FUNC_ALLOC, 2047, 1023), 1,
                         mk(ffa_pkg::ST_NOFIT, 0, 1024, 1024)});
        rows.push_back('{mkreq(ffa_pkg::FUNC_FREE, 0, 0), 1,
                         mk(ffa_pkg::ST_BADFREE, 0, 1024, 1024)});
        rows.push_back('{mkreq(ffa_pkg::FUNC_ALLOC, 1024, 0), 1,
                         mk(ffa_pkg::ST_OK, 0, 0, 0)});
        rows.push_back('{mkreq(ffa_pkg::FUNC_ALLOC, 1, 0), 1,
                         mk(ffa_pkg::ST_NOFIT, 0, 0, 0)});
        rows.push_back('{mkreq(ffa_pkg::FUNC_FREE, 0, 0), 1,
                         mk(ffa_pkg::ST_OK, 0, 1024, 1024)});
        rows.push_back('{mkreq(ffa_pkg::FUNC_ALLOC, 1, 0), 1,
                         mk(ffa_pkg::ST_OK, 0, 1023, 1023)});
        rows.push_back('{mkreq(ffa_pkg::FUNC_ALLOC, 1022, 0), 0, '0});
        rows.push_back('{mkreq(ffa_pkg::FUNC_ALLOC, 1, 0), 0, '0});
        rows.push_back('{mkreq(ffa_pkg::FUNC_FREE, 0, 0), 0, '0});
        rows.push_back('{mkreq(ffa_pkg::FUNC_FREE, 1023, 0), 0, '0});
        // merge on both sides
        rows.push_back('{mkreq(ffa_pkg::FUNC_FREE, 0, 1), 0, '0});
        rows.push_back('{mkreq(ffa_pkg::FUNC_FREE, 1, 1023), 1,
                         mk(ffa_pkg::ST_OK, 1023, 1024, 1024)});
        rows.push_back('{mkreq(ffa_pkg::FUNC_ALLOC, 100, 0), 0, '0});
        rows.push_back('{mkreq(ffa_pkg::FUNC_ALLOC, 200, 0), 0, '0});
        rows.push_back('{mkreq(ffa_pkg::FUNC_ALLOC, 300, 0), 0, '0});
        rows.push_back('{mkreq(ffa_pkg::FUNC_FREE, 0, 100), 0, '0});
        rows.push_back('{mkreq(ffa_pkg::FUNC_FREE, 0, 0), 0, '0});
        rows.push_back('{mkreq(ffa_pkg::FUNC_FREE, 0, 300), 0, '0});
        rows.push_back('{mkreq(ffa_pkg::FUNC_FREE, 0, 682), 0, '0});
        foreach (rows[k]) send_req(rows[k].r, rows[k].fixed, rows[k].o);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 40) hold_active = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                 : $urandom_range(1, 64);
                r = mkreq(ffa_pkg::FUNC_ALLOC, sz, $urandom_range(0, 1023));
            end else if (pick < 85 && live_offsets.size() > 0) begin
                r = mkreq(ffa_pkg::FUNC_FREE, $urandom_range(0, 2047),
                          live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
            end else begin
                r = mkreq(ffa_pkg::FUNC_FREE, $urandom_range(0, 2047),
                          $urandom_range(0, 1023));
            end
            send_req(r, 0, '0);
        end
        req_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_active) begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_active = 1'b0;
            end
            gap = $urandom_range(0, 7);
            if (gap > 0) begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            // transfer taken at this edge; next negedge decides ready again
        end
    end

    // result checker
    always @(posedge clk) begin
        ffa_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result %h", $time, rsp);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, rsp.status);
                    errors++;
                end
                if (rsp.block_offset !== want.block_offset) begin
                    $display("%0t: block_offset exp %0d got %0d", $time,
                             want.block_offset, rsp.block_offset);
                    errors++;
                end
                if (rsp.free_total !== want.free_total) begin
                    $display("%0t: free_total exp %0d got %0d", $time,
                             want.free_total, rsp.free_total);
                    errors++;
                end
                if (rsp.largest_free !== want.largest_free) begin
                    $display("%0t: largest_free exp %0d got %0d", $time,
                             want.largest_free, rsp.largest_free);
                    errors++;
                end
                if (rsp.fragmentation !== want.fragmentation) begin
                    $display("%0t: fragmentation exp %0d got %0d", $time,
                             want.fragmentation, rsp.fragmentation);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** first_fit_allocator_core: FAILED **");
            $finish;
        end
    end

    initial begin
        wait (sender_done);
        wait (pending_rsp.size() == 0);
        repeat (3 * ffa_pkg::MAX_SEGMENTS + 10) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("** first_fit_allocator_core: PASSED **");
        else
            $display("** first_fit_allocator_core: FAILED **");
        $finish;
    end

endmodule
